// File: hw/rtl/tfdr_pkg.sv
// ----------------------------------------------------------------------------
// tfdr_pkg
// Shared types and constants of the triangular filter dB response unit.
// ----------------------------------------------------------------------------
package tfdr_pkg;

    localparam int LOG_FRAC = 16;             // fraction bits of log2
    localparam int MW       = 31;             // normalized mantissa, 1.30
    localparam int KW       = 5;              // integer part of log2
    localparam int LGW      = KW + LOG_FRAC;  // log2 word

    localparam logic signed [15:0] FLOOR_Q88   = -16'sd30720;  // -120 dB
    localparam logic signed [15:0] ZERO_HZ_Q88 = -16'sd25600;  // -100 dB

    typedef enum logic [2:0] {
        CFG_SAMPLE_RATE = 3'd0,
        CFG_NUM_BINS    = 3'd1,
        CFG_CENTRE      = 3'd2,
        CFG_LOW_SLOPE   = 3'd3,
        CFG_HIGH_SLOPE  = 3'd4,
        CFG_GAIN        = 3'd5
    } t_cfg_idx;

    // item as it travels along the log2 cells
    typedef struct packed {
        logic [MW-1:0]       ma;
        logic [MW-1:0]       mb;
        logic [LOG_FRAC-1:0] fa;
        logic [LOG_FRAC-1:0] fb;
        logic [KW-1:0]       ka;
        logic [KW-1:0]       kb;
        logic                low;
        logic                zero;
    } t_cell;

endpackage

// File: hw/rtl/tfdr_norm.sv
// ----------------------------------------------------------------------------
// tfdr_norm
// Leading-one search and normalization of a value to a 1.30 mantissa.
// ----------------------------------------------------------------------------
module tfdr_norm import tfdr_pkg::*; (
    input  logic [MW-1:0] i_x,
    output logic [KW-1:0] o_k,
    output logic [MW-1:0] o_m
);

    always_comb begin
        o_k = '0;
        for (int i = 0; i < MW; i++) begin
            if (i_x[i]) begin
                o_k = KW'(i);
            end
        end
        o_m = i_x << (KW'(MW - 1) - o_k);
    end

endmodule

// File: hw/rtl/tfdr_log_cell.sv
// ----------------------------------------------------------------------------
// tfdr_log_cell
// One squaring step of the log2 fraction for both sides of the ratio.
// ----------------------------------------------------------------------------
module tfdr_log_cell import tfdr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_cell i_d,
    output logic  o_valid,
    output t_cell o_d
);

    logic [2*MW-1:0] sq_a, sq_b;
    logic [MW:0]     ta, tb;
    t_cell           n_d;

    always_comb begin
        sq_a = i_d.ma * i_d.ma;
        sq_b = i_d.mb * i_d.mb;
        ta   = sq_a[2*MW-1:MW-1];
        tb   = sq_b[2*MW-1:MW-1];
        n_d  = i_d;
        // square reaches 2: halve and emit a one bit
        n_d.ma = ta[MW] ? ta[MW:1] : ta[MW-1:0];
        n_d.mb = tb[MW] ? tb[MW:1] : tb[MW-1:0];
        n_d.fa = {i_d.fa[LOG_FRAC-2:0], ta[MW]};
        n_d.fb = {i_d.fb[LOG_FRAC-2:0], tb[MW]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d <= n_d;
        end
    end

endmodule

// File: hw/rtl/triangular_filter_db_response_unit.sv
// ----------------------------------------------------------------------------
// triangular_filter_db_response_unit
// Level in Q8.8 dB of a triangular filter at one spectral bin.
// ----------------------------------------------------------------------------
// Takes one bin index per cycle while o_in_stall is low and returns one level
// per item, in order. The pipeline is the row of 16 log2 cells, one per
// fraction bit, each squaring both sides of the frequency ratio, plus the
// ratio products, normalization, log difference, slope multiply and the
// output register. Every stage holds on its own, so bubbles close up when
// the output stalls. Configuration writes are always ready.
module triangular_filter_db_response_unit import tfdr_pkg::*; #(
    parameter int MAX_BINS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [9:0]  i_bin_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_level_db,
    output logic        o_low_side
);

    localparam int NBW    = $clog2(MAX_BINS + 1);
    localparam int CW     = (NBW > 11) ? NBW : 11;
    localparam int NCELLS = LOG_FRAC;

    logic [15:0]        r_sample_rate;
    logic [10:0]        r_num_bins;
    logic [14:0]        r_centre;
    logic signed [15:0] r_low_slope, r_high_slope, r_gain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= 16'd16000;
            r_num_bins    <= 11'd256;
            r_centre      <= 15'd100;
            r_low_slope   <= -16'sd6144;
            r_high_slope  <= -16'sd6144;
            r_gain        <= 16'sd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data;
                CFG_NUM_BINS:    r_num_bins    <= i_cfg_data[10:0];
                CFG_CENTRE:      r_centre      <= i_cfg_data[14:0];
                CFG_LOW_SLOPE:   r_low_slope   <= i_cfg_data;
                CFG_HIGH_SLOPE:  r_high_slope  <= i_cfg_data;
                CFG_GAIN:        r_gain        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables, back to front
    logic              en_s0, en_s1, en_diff, en_mul, en_out;
    logic [NCELLS-1:0] en_cell;
    logic              r_s0_v, r_s1_v, r_diff_v, r_mul_v, r_out_v;
    logic [NCELLS-1:0] cell_v;

    always_comb begin
        en_out  = !r_out_v || !i_out_stall;
        en_mul  = !r_mul_v || en_out;
        en_diff = !r_diff_v || en_mul;
        en_cell[NCELLS-1] = !cell_v[NCELLS-1] || en_diff;
        for (int i = NCELLS - 2; i >= 0; i--) begin
            en_cell[i] = !cell_v[i] || en_cell[i+1];
        end
        en_s1 = !r_s1_v || en_cell[0];
        en_s0 = !r_s0_v || en_s1;
    end

    assign o_in_stall = !en_s0;

    // stage 0: ratio terms A = centre*2*bins, B = bin*rate
    logic [CW-1:0] nb_eff;
    logic [14:0]   cf_eff;
    logic [MW-1:0] r_a, r_b;

    always_comb begin
        nb_eff = CW'(r_num_bins);
        if (nb_eff < CW'(2)) begin
            nb_eff = CW'(2);
        end else if (nb_eff > CW'(MAX_BINS)) begin
            nb_eff = CW'(MAX_BINS);
        end
        cf_eff = (r_centre == '0) ? 15'd1 : r_centre;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en_s0) begin
            r_s0_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s0) begin
            r_a <= MW'({(MW-1)'(cf_eff) * (MW-1)'(nb_eff), 1'b0});
            r_b <= MW'(i_bin_index) * MW'(r_sample_rate);
        end
    end

    // stage 1: compare and normalize
    logic [KW-1:0] ka, kb;
    logic [MW-1:0] ma, mb;
    t_cell         r_s1;

    tfdr_norm u_norm_a (.i_x(r_a), .o_k(ka), .o_m(ma));
    tfdr_norm u_norm_b (.i_x(r_b), .o_k(kb), .o_m(mb));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en_s1) begin
            r_s1_v <= r_s0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1.ma   <= ma;
            r_s1.mb   <= mb;
            r_s1.fa   <= '0;
            r_s1.fb   <= '0;
            r_s1.ka   <= ka;
            r_s1.kb   <= kb;
            r_s1.low  <= r_b < r_a;
            r_s1.zero <= r_b == '0;
        end
    end

    // row of log2 cells, one fraction bit each
    t_cell cell_d [NCELLS];

    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        if (g == 0) begin : g_first
            tfdr_log_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en_cell[g]),
                .i_valid(r_s1_v), .i_d(r_s1),
                .o_valid(cell_v[g]), .o_d(cell_d[g])
            );
        end else begin : g_next
            tfdr_log_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en_cell[g]),
                .i_valid(cell_v[g-1]), .i_d(cell_d[g-1]),
                .o_valid(cell_v[g]), .o_d(cell_d[g])
            );
        end
    end

    // log difference and slope select
    t_cell              last;
    logic [LGW-1:0]     la, lb;
    logic [LGW-1:0]     r_lg;
    logic signed [15:0] r_slope;
    logic               r_diff_low, r_diff_zero;

    assign last = cell_d[NCELLS-1];
    assign la   = {last.ka, last.fa};
    assign lb   = {last.kb, last.fb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_v <= 1'b0;
        end else if (en_diff) begin
            r_diff_v <= cell_v[NCELLS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_diff) begin
            r_lg        <= last.low ? (la - lb) : (lb - la);
            r_slope     <= last.low ? r_low_slope : r_high_slope;
            r_diff_low  <= last.low;
            r_diff_zero <= last.zero;
        end
    end

    // slope multiply
    logic signed [LGW+16:0] r_prod;
    logic                   r_mul_low, r_mul_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
        end else if (en_mul) begin
            r_mul_v <= r_diff_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_mul) begin
            r_prod     <= $signed({1'b0, r_lg}) * r_slope;
            r_mul_low  <= r_diff_low;
            r_mul_zero <= r_diff_zero;
        end
    end

    // round half up, add gain, clamp; bin 0 gets the 0 Hz level
    logic signed [LGW+17:0] rounded;
    logic signed [LGW+2:0]  q;
    logic signed [LGW+3:0]  lvl;
    logic signed [15:0]     n_level;

    always_comb begin
        rounded = (LGW+18)'(r_prod) + (LGW+18)'(32768);
        q       = (LGW+3)'(rounded >>> LOG_FRAC);
        lvl     = (LGW+4)'(q) + (LGW+4)'(r_gain);
        if (r_mul_low && r_mul_zero) begin
            n_level = ZERO_HZ_Q88;
        end else if (lvl < (LGW+4)'(FLOOR_Q88)) begin
            n_level = FLOOR_Q88;
        end else if (lvl > (LGW+4)'(32767)) begin
            n_level = 16'sd32767;
        end else begin
            n_level = lvl[15:0];
        end
    end

    logic [15:0] r_level;
    logic        r_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en_out) begin
            r_out_v <= r_mul_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_level <= n_level;
            r_low   <= r_mul_low;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_level_db  = r_level;
    assign o_low_side  = r_low;

    // input stalls only when the whole row is backed up behind the output
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while pipeline has room");

    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_level_db) >= FLOOR_Q88))
        else $error("level below floor");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule
